// File: rtl/core/sio_frame_master_handshake_macros.svh
// Assertion macros shared by the frame master RTL.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef SIO_FRAME_MASTER_HANDSHAKE_MACROS_SVH
`define SIO_FRAME_MASTER_HANDSHAKE_MACROS_SVH

`ifndef SYNTH
// The consequent must hold in the same cycle as the antecedent.
`define SFM_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define SFM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SFM_ASSERT_IMPL(lbl, ante, cons, msg)
`define SFM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: rtl/core/sio_fm_pkg.sv
`default_nettype none

package sio_fm_pkg;

	// Frame geometry.
	localparam int FRAME_BYTES = 25;
	// Store address width and byte counter width (the counter also walks the
	// five command frame slots, so it is never narrower than three bits).
	localparam int AW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
	localparam int CW = ($clog2(FRAME_BYTES + 1) > 3) ? $clog2(FRAME_BYTES + 1) : 3;

	// Command frame slots.
	localparam logic [2:0] SLOT_DEVICE  = 3'd0;
	localparam logic [2:0] SLOT_COMMAND = 3'd1;
	localparam logic [2:0] SLOT_AUX_ONE = 3'd2;
	localparam logic [2:0] SLOT_AUX_TWO = 3'd3;
	localparam logic [2:0] SLOT_CHECK   = 3'd4;

	// Configuration register indexes.
	localparam logic [1:0] CFG_DEVICE_ID    = 2'd0;
	localparam logic [1:0] CFG_COMMAND_CODE = 2'd1;
	localparam logic [1:0] CFG_AUX_ONE      = 2'd2;
	localparam logic [1:0] CFG_AUX_TWO      = 2'd3;

	// Configuration reset values.
	localparam logic [7:0] RST_DEVICE_ID    = 8'd115;
	localparam logic [7:0] RST_COMMAND_CODE = 8'h01;
	localparam logic [7:0] RST_AUX          = 8'h00;

	// Input kinds.
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_REPLY   = 1'b1;

	// Reply characters from the device.
	localparam logic [7:0] CH_ACK      = 8'h41;
	localparam logic [7:0] CH_NAK      = 8'h4E;
	localparam logic [7:0] CH_COMPLETE = 8'h43;
	localparam logic [7:0] CH_ERROR    = 8'h45;

	typedef enum logic [2:0] {
		ST_NONE     = 3'd0,
		ST_ACK      = 3'd1,
		ST_NAK      = 3'd2,
		ST_COMPLETE = 3'd3,
		ST_DEVERR   = 3'd4,
		ST_PROTERR  = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		CTL_IDLE,
		CTL_CMD,
		CTL_PAY,
		CTL_STAT
	} ctl_state_t;

	typedef enum logic [1:0] {
		PH_COLLECT,
		PH_REPLY1,
		PH_REPLY2,
		PH_FINISH
	} phase_t;

	typedef enum logic [1:0] {
		OSEL_CMD,
		OSEL_PAY,
		OSEL_STAT
	} out_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic     load_byte;
		logic     clear_frame;
		logic     idx_clear;
		logic     idx_inc;
		logic     ck_clear;
		logic     out_load;
		out_sel_t out_sel;
		status_t  out_status;
		logic     out_last;
	} sfm_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic frame_done;
		logic idx_cmd_end;
		logic idx_pay_end;
		logic out_free;
	} sfm_sts_t;

	// End-around-carry add: a carry out of bit 7 is folded back into bit 0.
	function automatic logic [7:0] eac_add(input logic [7:0] a, input logic [7:0] b);
		logic [8:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[8] ? (s[7:0] + 8'd1) : s[7:0];
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/sio_fm_ifs.sv
`default_nettype none

// Input channel: one payload or reply byte per transaction.
interface sio_fm_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] byte_value;

	modport source (output valid, output kind, output byte_value, input ready);
	modport sink (input valid, input kind, input byte_value, output ready);
endinterface

// Output channel: one transmit byte or status report per transaction.
interface sio_fm_out_if;
	logic       valid;
	logic       ready;
	logic       is_tx;
	logic [7:0] tx_byte;
	logic [2:0] status;
	logic       last;

	modport source (output valid, output is_tx, output tx_byte, output status,
		output last, input ready);
	modport sink (input valid, input is_tx, input tx_byte, input status,
		input last, output ready);
endinterface

`default_nettype wire

// File: rtl/core/sio_fm_ctrl.sv
`default_nettype none

module sio_fm_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic                 kind,
	input  wire logic [7:0]           byte_value,
	input  wire sio_fm_pkg::sfm_sts_t sts,
	output sio_fm_pkg::sfm_cmd_t      cmd
);

	sio_fm_pkg::ctl_state_t state_q, state_d;
	sio_fm_pkg::phase_t     phase_q, phase_d;
	sio_fm_pkg::status_t    stat_q, stat_d;

	logic accept;
	logic is_ack;
	logic is_an;
	logic pay_acc;
	logic rep_acc;

	// Input decode.
	always_comb begin
		in_ready = (state_q == sio_fm_pkg::CTL_IDLE);
		accept   = in_valid && in_ready;
		is_ack   = (byte_value == sio_fm_pkg::CH_ACK);
		is_an    = is_ack || (byte_value == sio_fm_pkg::CH_NAK);
		pay_acc  = accept && (kind == sio_fm_pkg::KIND_PAYLOAD)
			&& (phase_q == sio_fm_pkg::PH_COLLECT);
		rep_acc  = accept && (kind == sio_fm_pkg::KIND_REPLY);
	end

	// Next state, protocol phase and pending status code.
	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		stat_d  = stat_q;
		unique case (state_q)
			sio_fm_pkg::CTL_IDLE: begin
				if (pay_acc && sts.frame_done) begin
					state_d = sio_fm_pkg::CTL_CMD;
					phase_d = sio_fm_pkg::PH_REPLY1;
				end else if (rep_acc) begin
					unique case (phase_q)
						sio_fm_pkg::PH_COLLECT: begin
							state_d = sio_fm_pkg::CTL_IDLE;
						end
						sio_fm_pkg::PH_REPLY1: begin
							if (is_an) begin
								state_d = sio_fm_pkg::CTL_PAY;
								phase_d = sio_fm_pkg::PH_REPLY2;
								stat_d  = is_ack ? sio_fm_pkg::ST_ACK : sio_fm_pkg::ST_NAK;
							end else begin
								state_d = sio_fm_pkg::CTL_STAT;
								phase_d = sio_fm_pkg::PH_COLLECT;
								stat_d  = sio_fm_pkg::ST_PROTERR;
							end
						end
						sio_fm_pkg::PH_REPLY2: begin
							state_d = sio_fm_pkg::CTL_STAT;
							if (is_an) begin
								phase_d = sio_fm_pkg::PH_FINISH;
								stat_d  = is_ack ? sio_fm_pkg::ST_ACK : sio_fm_pkg::ST_NAK;
							end else begin
								phase_d = sio_fm_pkg::PH_COLLECT;
								stat_d  = sio_fm_pkg::ST_PROTERR;
							end
						end
						sio_fm_pkg::PH_FINISH: begin
							state_d = sio_fm_pkg::CTL_STAT;
							phase_d = sio_fm_pkg::PH_COLLECT;
							if (byte_value == sio_fm_pkg::CH_COMPLETE) begin
								stat_d = sio_fm_pkg::ST_COMPLETE;
							end else if (byte_value == sio_fm_pkg::CH_ERROR) begin
								stat_d = sio_fm_pkg::ST_DEVERR;
							end else begin
								stat_d = sio_fm_pkg::ST_PROTERR;
							end
						end
						default: begin
							state_d = sio_fm_pkg::CTL_IDLE;
						end
					endcase
				end
			end
			sio_fm_pkg::CTL_CMD: begin
				if (sts.out_free && sts.idx_cmd_end) begin
					state_d = sio_fm_pkg::CTL_IDLE;
				end
			end
			sio_fm_pkg::CTL_PAY: begin
				if (sts.out_free && sts.idx_pay_end) begin
					state_d = sio_fm_pkg::CTL_IDLE;
				end
			end
			sio_fm_pkg::CTL_STAT: begin
				if (sts.out_free) begin
					state_d = sio_fm_pkg::CTL_IDLE;
				end
			end
			default: begin
				state_d = sio_fm_pkg::CTL_IDLE;
			end
		endcase
	end

	// Datapath commands.
	always_comb begin
		cmd = '0;
		cmd.out_sel    = sio_fm_pkg::OSEL_STAT;
		cmd.out_status = sio_fm_pkg::ST_NONE;
		unique case (state_q)
			sio_fm_pkg::CTL_IDLE: begin
				cmd.load_byte = pay_acc;
				cmd.ck_clear  = pay_acc && sts.frame_done;
				cmd.idx_clear = (pay_acc && sts.frame_done)
					|| (rep_acc && (phase_q == sio_fm_pkg::PH_REPLY1) && is_an);
				// Protocol errors and the end of the exchange restart collection.
				cmd.clear_frame = rep_acc && (
					((phase_q == sio_fm_pkg::PH_REPLY1) && !is_an)
					|| ((phase_q == sio_fm_pkg::PH_REPLY2) && !is_an)
					|| (phase_q == sio_fm_pkg::PH_FINISH));
			end
			sio_fm_pkg::CTL_CMD: begin
				cmd.out_load = sts.out_free;
				cmd.idx_inc  = sts.out_free;
				cmd.out_sel  = sio_fm_pkg::OSEL_CMD;
				cmd.out_last = sts.idx_cmd_end;
			end
			sio_fm_pkg::CTL_PAY: begin
				cmd.out_load   = sts.out_free;
				cmd.idx_inc    = sts.out_free;
				cmd.out_sel    = sio_fm_pkg::OSEL_PAY;
				cmd.out_status = stat_q;
				cmd.out_last   = sts.idx_pay_end;
			end
			sio_fm_pkg::CTL_STAT: begin
				cmd.out_load   = sts.out_free;
				cmd.out_sel    = sio_fm_pkg::OSEL_STAT;
				cmd.out_status = stat_q;
				cmd.out_last   = 1'b1;
			end
			default: begin
				cmd.out_load = 1'b0;
			end
		endcase
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sio_fm_pkg::CTL_IDLE;
			phase_q <= sio_fm_pkg::PH_COLLECT;
			stat_q  <= sio_fm_pkg::ST_NONE;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			stat_q  <= stat_d;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/sio_fm_dp.sv
`default_nettype none

module sio_fm_dp (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire sio_fm_pkg::sfm_cmd_t cmd,
	output sio_fm_pkg::sfm_sts_t      sts,
	input  wire logic [7:0]           byte_value,
	input  wire logic                 cfg_we,
	input  wire logic [1:0]           cfg_index,
	input  wire logic [7:0]           cfg_data,
	sio_fm_out_if.source              result
);

	logic [7:0] device_id_q;
	logic [7:0] command_code_q;
	logic [7:0] aux_one_q;
	logic [7:0] aux_two_q;

	logic [7:0] store_q [sio_fm_pkg::FRAME_BYTES];
	logic [sio_fm_pkg::CW-1:0] fill_q;
	logic [sio_fm_pkg::CW-1:0] idx_q;
	logic [7:0] pck_q;
	logic [7:0] cck_q;

	logic       out_valid_q;
	logic       out_is_tx_q;
	logic [7:0] out_byte_q;
	logic [2:0] out_status_q;
	logic       out_last_q;

	logic [7:0] cmd_byte;

	// Status toward the controller.
	always_comb begin
		sts.frame_done  = (fill_q == sio_fm_pkg::CW'(sio_fm_pkg::FRAME_BYTES - 1));
		sts.idx_cmd_end = (idx_q == sio_fm_pkg::CW'(sio_fm_pkg::SLOT_CHECK));
		sts.idx_pay_end = (idx_q == sio_fm_pkg::CW'(sio_fm_pkg::FRAME_BYTES));
		sts.out_free    = !out_valid_q || result.ready;
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_id_q    <= sio_fm_pkg::RST_DEVICE_ID;
			command_code_q <= sio_fm_pkg::RST_COMMAND_CODE;
			aux_one_q      <= sio_fm_pkg::RST_AUX;
			aux_two_q      <= sio_fm_pkg::RST_AUX;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sio_fm_pkg::CFG_DEVICE_ID:    device_id_q    <= cfg_data;
				sio_fm_pkg::CFG_COMMAND_CODE: command_code_q <= cfg_data;
				sio_fm_pkg::CFG_AUX_ONE:      aux_one_q      <= cfg_data;
				sio_fm_pkg::CFG_AUX_TWO:      aux_two_q      <= cfg_data;
				default:                      aux_two_q      <= aux_two_q;
			endcase
		end
	end

	// Frame store: written at the fill count while collecting.
	always_ff @(posedge clk) begin
		if (cmd.load_byte) begin
			store_q[fill_q[sio_fm_pkg::AW-1:0]] <= byte_value;
		end
	end

	// Fill count and running payload checksum.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			pck_q  <= '0;
		end else if (cmd.clear_frame) begin
			fill_q <= '0;
			pck_q  <= '0;
		end else if (cmd.load_byte) begin
			fill_q <= fill_q + 1'b1;
			pck_q  <= sio_fm_pkg::eac_add(pck_q, byte_value);
		end
	end

	// Byte index that walks the command frame and the payload.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.idx_clear) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	// Command frame byte and its checksum, built up as the bytes go out.
	always_comb begin
		unique case (idx_q[2:0])
			sio_fm_pkg::SLOT_DEVICE:  cmd_byte = device_id_q;
			sio_fm_pkg::SLOT_COMMAND: cmd_byte = command_code_q;
			sio_fm_pkg::SLOT_AUX_ONE: cmd_byte = aux_one_q;
			sio_fm_pkg::SLOT_AUX_TWO: cmd_byte = aux_two_q;
			default:                  cmd_byte = cck_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.ck_clear) begin
			cck_q <= '0;
		end else if (cmd.out_load && (cmd.out_sel == sio_fm_pkg::OSEL_CMD)
			&& !sts.idx_cmd_end) begin
			cck_q <= sio_fm_pkg::eac_add(cck_q, cmd_byte);
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload: a command frame byte, a stored payload byte, the payload checksum
	// after the last stored byte, or zero for a status report.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_is_tx_q  <= (cmd.out_sel != sio_fm_pkg::OSEL_STAT);
			out_status_q <= cmd.out_status;
			out_last_q   <= cmd.out_last;
			unique case (cmd.out_sel)
				sio_fm_pkg::OSEL_CMD: out_byte_q <= cmd_byte;
				sio_fm_pkg::OSEL_PAY: begin
					if (sts.idx_pay_end) begin
						out_byte_q <= pck_q;
					end else begin
						out_byte_q <= store_q[idx_q[sio_fm_pkg::AW-1:0]];
					end
				end
				default:              out_byte_q <= 8'h00;
			endcase
		end
	end

	assign result.valid   = out_valid_q;
	assign result.is_tx   = out_is_tx_q;
	assign result.tx_byte = out_byte_q;
	assign result.status  = out_status_q;
	assign result.last    = out_last_q;

endmodule

`default_nettype wire

// File: rtl/core/sio_frame_master_handshake.sv
// An accepted byte that causes results moves the controller out of idle, and its first
// result then goes into the output register; results leave one per cycle while the
// output side takes them. No byte is taken until the controller, walking the command
// frame or the frame store, has loaded every result; a byte with no result leaves it idle.
// Reset: configuration returns to its defaults, fill count and payload checksum clear,
// the block collects payload and the output register is empty; the store is not cleared.
`default_nettype none

`include "sio_frame_master_handshake_macros.svh"

module sio_frame_master_handshake (
	input  wire logic       clk,
	input  wire logic       arst_n,
	sio_fm_in_if.sink       item,
	sio_fm_out_if.source    result,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_data
);

	sio_fm_pkg::sfm_cmd_t cmd;
	sio_fm_pkg::sfm_sts_t sts;
	logic                 in_ready;

	assign item.ready = in_ready;

	// Protocol sequencer.
	sio_fm_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (item.valid),
		.in_ready   (in_ready),
		.kind       (item.kind),
		.byte_value (item.byte_value),
		.sts        (sts),
		.cmd        (cmd)
	);

	// Store, checksums, configuration and output register.
	sio_fm_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.byte_value (item.byte_value),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.result     (result)
	);

	// No result is produced in a cycle where a new transaction can be taken.
	`SFM_ASSERT_IMPL(a_ready_no_load, item.ready, !cmd.out_load, "result loaded while ready")
	// The payload byte that completes a frame stops input for the command frame.
	`SFM_ASSERT_NEXT(a_full_frame_stall, item.valid && item.ready
		&& (item.kind == sio_fm_pkg::KIND_PAYLOAD) && sts.frame_done && !cmd.clear_frame,
		!item.ready, "input taken after full frame")
	// A status report is always the only result of its input.
	`SFM_ASSERT_IMPL(a_status_last, result.valid && !result.is_tx, result.last,
		"status report not marked last")

endmodule

`default_nettype wire

// File: test/tb_sio_frame_master_handshake.sv
`timescale 1ns / 100ps

module tb_sio_frame_master_handshake;
	import sio_fm_pkg::*;

	// Cycles with no transaction on either channel before the run is abandoned.
	localparam int STALL_LIMIT = 2000;
	// Non-ignored random bytes sent in each phase of the random part.
	localparam int BYTES_PER_PHASE = 55;
	localparam int RANDOM_PHASES = 6;

	// One transmit byte or status report coming out of the block.
	typedef struct packed {
		logic       is_tx;
		logic [7:0] tx_byte;
		status_t    status;
		logic       last;
	} out_beat_t;

	// One row of the directed script: a byte, how many times it is sent, and
	// optionally the single status report (or silence) it must cause.
	typedef struct {
		logic       kind;
		logic [7:0] value;
		int         reps;
		bit         typed;
		int         typed_n;
		status_t    typed_st;
	} script_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [7:0] cfg_data;

	sio_fm_in_if  item_if ();
	sio_fm_out_if result_if ();

	sio_frame_master_handshake u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_if),
		.result    (result_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Shadow copy of the frame master: configuration, store and protocol phase.
	logic [7:0] m_device = RST_DEVICE_ID;
	logic [7:0] m_command = RST_COMMAND_CODE;
	logic [7:0] m_aux_one = RST_AUX;
	logic [7:0] m_aux_two = RST_AUX;
	logic [7:0] m_store [FRAME_BYTES];
	int         m_fill = 0;
	logic [7:0] m_sum = 8'h00;
	phase_t     m_phase = PH_COLLECT;

	out_beat_t frame_out_q [$];

	int sender_idle_pct = 0;
	int sink_stall_pct = 0;
	int idle_cycles = 0;
	int n_mismatch = 0;
	int n_items = 0;
	int n_results = 0;
	int n_cmd_frames = 0;
	int n_complete = 0;
	int n_deverr = 0;
	int n_proterr = 0;

	// Directed script: ignored bytes, every reply path, payload extremes.
	script_row_t script [21] = '{
		'{KIND_REPLY,   CH_ACK,      1,  1'b1, 0, ST_NONE},
		'{KIND_PAYLOAD, 8'hFF,       25, 1'b0, 0, ST_NONE},
		'{KIND_PAYLOAD, 8'h00,       1,  1'b1, 0, ST_NONE},
		'{KIND_REPLY,   8'h00,       1,  1'b1, 1, ST_PROTERR},
		'{KIND_PAYLOAD, 8'h00,       25, 1'b0, 0, ST_NONE},
		'{KIND_REPLY,   CH_ACK,      1,  1'b0, 0, ST_NONE},
		'{KIND_REPLY,   CH_NAK,      1,  1'b1, 1, ST_NAK},
		'{KIND_PAYLOAD, 8'h12,       1,  1'b1, 0, ST_NONE},
		'{KIND_REPLY,   CH_COMPLETE, 1,  1'b1, 1, ST_COMPLETE},
		'{KIND_PAYLOAD, 8'h01,       24, 1'b0, 0, ST_NONE},
		'{KIND_PAYLOAD, 8'h80,       1,  1'b0, 0, ST_NONE},
		'{KIND_REPLY,   CH_NAK,      1,  1'b0, 0, ST_NONE},
		'{KIND_REPLY,   CH_ACK,      1,  1'b1, 1, ST_ACK},
		'{KIND_REPLY,   CH_ERROR,    1,  1'b1, 1, ST_DEVERR},
		'{KIND_PAYLOAD, 8'hFE,       25, 1'b0, 0, ST_NONE},
		'{KIND_REPLY,   CH_ACK,      1,  1'b0, 0, ST_NONE},
		'{KIND_REPLY,   8'hFF,       1,  1'b1, 1, ST_PROTERR},
		'{KIND_PAYLOAD, 8'h7F,       25, 1'b0, 0, ST_NONE},
		'{KIND_REPLY,   CH_NAK,      1,  1'b0, 0, ST_NONE},
		'{KIND_REPLY,   CH_NAK,      1,  1'b1, 1, ST_NAK},
		'{KIND_REPLY,   CH_ACK,      1,  1'b1, 1, ST_PROTERR}
	};

	// Clock.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Add with the carry folded back in: subtract 255 when the sum overflows a byte.
	function automatic logic [7:0] fold_add(input logic [7:0] a, input logic [7:0] b);
		int unsigned s;
		s = a + b;
		if (s > 255) begin
			s = s - 255;
		end
		return s[7:0];
	endfunction

	// Advance the shadow frame master by one accepted byte and, if asked,
	// queue the results it must produce.
	task automatic frame_master_step(input logic k, input logic [7:0] v, input bit record);
		out_beat_t beats [$];
		status_t st;
		logic [7:0] ck;
		if (k == KIND_PAYLOAD) begin
			if (m_phase == PH_COLLECT) begin
				if (m_fill < FRAME_BYTES) begin
					m_store[m_fill] = v;
					m_fill++;
					m_sum = fold_add(m_sum, v);
				end
				if (m_fill >= FRAME_BYTES) begin
					ck = fold_add(fold_add(fold_add(m_device, m_command), m_aux_one), m_aux_two);
					beats.push_back('{1'b1, m_device, ST_NONE, 1'b0});
					beats.push_back('{1'b1, m_command, ST_NONE, 1'b0});
					beats.push_back('{1'b1, m_aux_one, ST_NONE, 1'b0});
					beats.push_back('{1'b1, m_aux_two, ST_NONE, 1'b0});
					beats.push_back('{1'b1, ck, ST_NONE, 1'b0});
					m_phase = PH_REPLY1;
					n_cmd_frames++;
				end
			end
		end else begin
			case (m_phase)
				PH_REPLY1: begin
					if (v == CH_ACK || v == CH_NAK) begin
						st = (v == CH_ACK) ? ST_ACK : ST_NAK;
						for (int i = 0; i < FRAME_BYTES; i++) begin
							beats.push_back('{1'b1, m_store[i], st, 1'b0});
						end
						beats.push_back('{1'b1, m_sum, st, 1'b0});
						m_phase = PH_REPLY2;
					end else begin
						beats.push_back('{1'b0, 8'h00, ST_PROTERR, 1'b0});
					end
				end
				PH_REPLY2: begin
					if (v == CH_ACK || v == CH_NAK) begin
						st = (v == CH_ACK) ? ST_ACK : ST_NAK;
						beats.push_back('{1'b0, 8'h00, st, 1'b0});
						m_phase = PH_FINISH;
					end else begin
						beats.push_back('{1'b0, 8'h00, ST_PROTERR, 1'b0});
					end
				end
				PH_FINISH: begin
					if (v == CH_COMPLETE) begin
						beats.push_back('{1'b0, 8'h00, ST_COMPLETE, 1'b0});
						n_complete++;
					end else if (v == CH_ERROR) begin
						beats.push_back('{1'b0, 8'h00, ST_DEVERR, 1'b0});
						n_deverr++;
					end else begin
						beats.push_back('{1'b0, 8'h00, ST_PROTERR, 1'b0});
					end
					m_phase = PH_COLLECT;
				end
				default: begin
				end
			endcase
			// A protocol error drops the partial frame and goes back to collecting.
			if (beats.size() > 0 && beats[beats.size() - 1].status == ST_PROTERR) begin
				n_proterr++;
				m_phase = PH_COLLECT;
			end
			// A reply ignored while collecting leaves the partial frame alone.
			if (beats.size() > 0 && m_phase == PH_COLLECT) begin
				m_fill = 0;
				m_sum = 8'h00;
			end
		end
		if (beats.size() > 0) begin
			beats[beats.size() - 1].last = 1'b1;
		end
		if (record) begin
			foreach (beats[i]) begin
				frame_out_q.push_back(beats[i]);
			end
		end
	endtask

	task automatic flag_mismatch(input string what);
		n_mismatch++;
		$display("[%0t] MISMATCH: %s", $realtime, what);
	endtask

	// Offer one byte on the input channel and update the shadow on acceptance.
	// A typed row queues its fixed status report instead of the predicted one.
	task automatic push_item(input logic k, input logic [7:0] v, input bit typed,
			input int typed_n, input status_t typed_st);
		@(negedge clk);
		while ($urandom_range(99) < sender_idle_pct) begin
			item_if.valid <= 1'b0;
			@(negedge clk);
		end
		item_if.valid <= 1'b1;
		item_if.kind <= k;
		item_if.byte_value <= v;
		@(posedge clk);
		while (!item_if.ready) begin
			@(posedge clk);
		end
		n_items++;
		frame_master_step(k, v, !typed);
		if (typed && typed_n > 0) begin
			frame_out_q.push_back('{1'b0, 8'h00, typed_st, 1'b1});
		end
	endtask

	// Drop valid and wait until every queued result has come out.
	task automatic wait_drained();
		@(negedge clk);
		item_if.valid <= 1'b0;
		while (frame_out_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_DEVICE_ID:    m_device = val;
			CFG_COMMAND_CODE: m_command = val;
			CFG_AUX_ONE:      m_aux_one = val;
			CFG_AUX_TWO:      m_aux_two = val;
			default: begin
			end
		endcase
	endtask

	task automatic write_all_regs(input logic [7:0] dev, input logic [7:0] cmd,
			input logic [7:0] a1, input logic [7:0] a2);
		write_reg(CFG_DEVICE_ID, dev);
		write_reg(CFG_COMMAND_CODE, cmd);
		write_reg(CFG_AUX_ONE, a1);
		write_reg(CFG_AUX_TWO, a2);
	endtask

	// Output side: random backpressure, changed at the falling edge.
	always @(negedge clk) begin
		result_if.ready <= ($urandom_range(99) >= sink_stall_pct);
	end

	// Compare every accepted result with the oldest queued one.
	always @(posedge clk) begin : result_check
		out_beat_t want;
		if (arst_n && result_if.valid && result_if.ready) begin
			n_results++;
			if (frame_out_q.size() == 0) begin
				flag_mismatch($sformatf("unexpected result is_tx=%0d byte=%02h status=%0d last=%0d",
					result_if.is_tx, result_if.tx_byte, result_if.status, result_if.last));
			end else begin
				want = frame_out_q.pop_front();
				if (result_if.is_tx !== want.is_tx || result_if.tx_byte !== want.tx_byte ||
						result_if.status !== want.status || result_if.last !== want.last) begin
					flag_mismatch($sformatf(
						"got is_tx=%0d byte=%02h status=%0d last=%0d, want %0d %02h %0d %0d",
						result_if.is_tx, result_if.tx_byte, result_if.status, result_if.last,
						want.is_tx, want.tx_byte, want.status, want.last));
				end
			end
		end
	end

	// Watchdog on cycles where neither channel moves a transaction.
	always @(posedge clk) begin
		if (!arst_n || (item_if.valid && item_if.ready) ||
				(result_if.valid && result_if.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles + 1 >= STALL_LIMIT) begin
				$display("Watchdog: no transaction for %0d cycles, %0d results outstanding",
					STALL_LIMIT, frame_out_q.size());
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// Stimulus.
	initial begin
		logic k;
		logic [7:0] v;
		int roll;
		int taken;
		int mode;
		bit ignored;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_DEVICE_ID;
		cfg_data = 8'h00;
		item_if.valid = 1'b0;
		item_if.kind = KIND_PAYLOAD;
		item_if.byte_value = 8'h00;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part, run on the reset configuration.
		foreach (script[r]) begin
			for (int j = 0; j < script[r].reps; j++) begin
				push_item(script[r].kind, script[r].value, script[r].typed,
					script[r].typed_n, script[r].typed_st);
			end
		end

		// Random part: several register settings, each with one of four idling modes.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			wait_drained();
			case (p)
				0: write_all_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF);
				1: write_all_regs(8'h00, 8'h00, 8'h00, 8'h00);
				default: write_all_regs(8'($urandom_range(255)), 8'($urandom_range(255)),
					8'($urandom_range(255)), 8'($urandom_range(255)));
			endcase
			mode = p % 4;
			sender_idle_pct = (mode == 1) ? 48 : (mode == 3) ? 10 : 0;
			sink_stall_pct = (mode == 2) ? 48 : (mode == 3) ? 10 : 0;
			taken = 0;
			while (taken < BYTES_PER_PHASE) begin
				roll = $urandom_range(99);
				v = 8'($urandom_range(255));
				if (m_phase == PH_COLLECT) begin
					k = (roll < 5) ? KIND_REPLY : KIND_PAYLOAD;
				end else if (roll < 8) begin
					k = KIND_PAYLOAD;
				end else begin
					k = KIND_REPLY;
					// Mostly the reply the block is waiting for, sometimes garbage.
					if (roll >= 16) begin
						if (m_phase == PH_FINISH) begin
							v = $urandom_range(1) ? CH_COMPLETE : CH_ERROR;
						end else begin
							v = $urandom_range(1) ? CH_ACK : CH_NAK;
						end
					end
				end
				ignored = (k == KIND_PAYLOAD) ? (m_phase != PH_COLLECT) : (m_phase == PH_COLLECT);
				push_item(k, v, 1'b0, 0, ST_NONE);
				if (!ignored) begin
					taken++;
				end
			end
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (frame_out_q.size() != 0) begin
			flag_mismatch($sformatf("%0d results never arrived", frame_out_q.size()));
		end
		$display("Run covered %0d input bytes and %0d results over %0d command frames.",
			n_items, n_results, n_cmd_frames);
		$display("Replies seen: %0d completions, %0d device errors, %0d protocol aborts.",
			n_complete, n_deverr, n_proterr);
		if (n_mismatch == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
